// File: rtl/utf8d_pkg.sv
package utf8d_pkg;

	localparam logic [20:0] REPL_CP = 21'h00FFFD;

	// entry queue between decode front and result back
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_replacement;
		logic        last_of_run;
	} out_item_t;

	// one entry per byte that yields results; a two-result byte always
	// leads with a replacement, so only the final result is stored
	typedef struct packed {
		logic        has_two;
		logic [20:0] code_point;
		logic        is_replacement;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} entry_wr_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} entry_rd_t;

endpackage

// File: rtl/utf8d_front.sv
module utf8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  utf8d_pkg::in_item_t item,
	output utf8d_pkg::entry_wr_t wr
);

	logic [20:0] partial_q;
	logic [1:0]  remaining_q;

	logic [20:0] partial_d;
	logic [1:0]  remaining_d;

	// lead decode of the incoming byte
	logic        lead_emit;
	logic [20:0] lead_cp;
	logic        lead_repl;
	logic [20:0] lead_partial;
	logic [1:0]  lead_remaining;

	logic [7:0]  b;
	logic        eos;
	logic        is_cont;
	logic [20:0] shifted;
	logic [1:0]  rem_dec;

	assign b       = item.data_byte;
	assign eos     = item.end_of_string;
	assign is_cont = (b[7:6] == 2'b10);
	assign shifted = {partial_q[14:0], b[5:0]};
	assign rem_dec = remaining_q - 2'd1;

	always_comb begin
		lead_emit      = 1'b0;
		lead_cp        = utf8d_pkg::REPL_CP;
		lead_repl      = 1'b1;
		lead_partial   = '0;
		lead_remaining = 2'd0;
		if (b[7] == 1'b0) begin
			lead_emit = 1'b1;
			lead_cp   = {13'd0, b};
			lead_repl = 1'b0;
		end else if (b[7:5] == 3'b110) begin
			lead_partial   = {16'd0, b[4:0]};
			lead_remaining = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			lead_partial   = {17'd0, b[3:0]};
			lead_remaining = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			lead_partial   = {18'd0, b[2:0]};
			lead_remaining = 2'd3;
		end else begin
			lead_emit = 1'b1;
		end
		// opened sequence cut off by end of string
		if (lead_remaining != 2'd0 && eos) begin
			lead_emit      = 1'b1;
			lead_partial   = '0;
			lead_remaining = 2'd0;
		end
	end

	always_comb begin
		wr.valid                = 1'b0;
		wr.entry.has_two        = 1'b0;
		wr.entry.code_point     = utf8d_pkg::REPL_CP;
		wr.entry.is_replacement = 1'b1;
		partial_d               = partial_q;
		remaining_d             = remaining_q;
		if (remaining_q == 2'd0) begin
			wr.valid                = lead_emit;
			wr.entry.code_point     = lead_cp;
			wr.entry.is_replacement = lead_repl;
			partial_d               = lead_partial;
			remaining_d             = lead_remaining;
		end else if (is_cont) begin
			if (rem_dec == 2'd0) begin
				wr.valid                = 1'b1;
				wr.entry.code_point     = shifted;
				wr.entry.is_replacement = 1'b0;
				partial_d               = '0;
				remaining_d             = 2'd0;
			end else if (eos) begin
				wr.valid    = 1'b1;
				partial_d   = '0;
				remaining_d = 2'd0;
			end else begin
				partial_d   = shifted;
				remaining_d = rem_dec;
			end
		end else begin
			// interrupted sequence, then the byte as a new lead
			wr.valid    = 1'b1;
			partial_d   = lead_partial;
			remaining_d = lead_remaining;
			if (lead_emit) begin
				wr.entry.has_two        = 1'b1;
				wr.entry.code_point     = lead_cp;
				wr.entry.is_replacement = lead_repl;
			end
		end
		if (!accept) begin
			wr.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			remaining_q <= 2'd0;
		end else if (accept) begin
			partial_q   <= partial_d;
			remaining_q <= remaining_d;
		end
	end

endmodule

// File: rtl/utf8d_fifo.sv
module utf8d_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utf8d_pkg::entry_wr_t  wr,
	input  logic                  rd,
	output logic                  full,
	output utf8d_pkg::entry_rd_t  q
);

	utf8d_pkg::entry_t mem [utf8d_pkg::QDEPTH];

	logic [utf8d_pkg::QAW-1:0] wptr_q;
	logic [utf8d_pkg::QAW-1:0] rptr_q;
	logic [utf8d_pkg::QAW:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == (utf8d_pkg::QAW+1)'(utf8d_pkg::QDEPTH));
	assign q.empty = (count_q == '0);
	assign q.head  = mem[rptr_q];
	assign do_wr   = wr.valid && !full;
	assign do_rd   = rd && !q.empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/utf8d_back.sv
module utf8d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utf8d_pkg::entry_rd_t  q,
	output logic                  rd,
	input  logic                  pop,
	output logic                  empty,
	output utf8d_pkg::out_item_t  result
);

	// set once the leading replacement of a two-result entry is taken
	logic first_done_q;
	logic on_first;

	assign empty    = q.empty;
	assign on_first = q.head.has_two && !first_done_q;
	assign rd       = pop && !q.empty && !on_first;

	always_comb begin
		if (on_first) begin
			result.code_point     = utf8d_pkg::REPL_CP;
			result.is_replacement = 1'b1;
			result.last_of_run    = 1'b0;
		end else begin
			result.code_point     = q.head.code_point;
			result.is_replacement = q.head.is_replacement;
			result.last_of_run    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_done_q <= 1'b0;
		end else if (pop && !q.empty) begin
			first_done_q <= on_first;
		end
	end

endmodule

// File: rtl/utf8_stream_decoder.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------------
// item    | in        | push / full        | data_byte, end_of_string
// result  | out       | empty / pop        | code_point, is_replacement, last_of_run
//
// one byte is taken per cycle while full is low; the decode front and its
// state update finish in the accept cycle, so no stall comes from the decode
// a byte with two results holds the queue head for two pops, so the sustained
// rate is one result per cycle on the result side while empty is low
// a four-entry queue parts the two sides: bytes keep flowing while results wait
// reset (arst_n low) closes any open sequence and empties the queue
module utf8_stream_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  utf8d_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t result
);

	utf8d_pkg::entry_wr_t wr;
	utf8d_pkg::entry_rd_t q;
	logic                 accept;
	logic                 rd;

	// an input transaction completes when push meets a non-full queue
	assign accept = push && !full;

	// front: sequence state and per-byte classification
	utf8d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.wr     (wr)
	);

	// queue of decoded entries, one per byte that yields results
	utf8d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.full   (full),
		.q      (q)
	);

	// back: unpacks each entry into one or two result transactions
	utf8d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.rd     (rd),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
